// ===== design/csf_pkg.sv =====
// Shared types and codes for the counting semaphore with FIFO wait queue.
`timescale 1ns / 1ps

package csf_pkg;

  // Field widths of the request and reply beats
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned REQ_ID_W   = 8;
  localparam int unsigned REPLY_ID_W = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LIMIT_W    = 8;

  // Request kinds
  localparam logic [CMD_W-1:0] CMD_WAIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SIGNAL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd3;

  // Reply kinds
  localparam logic KIND_WAIT  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Reply status codes
  localparam logic [STATUS_W-1:0] STAT_GRANTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIG,
    ST_DES,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // take the request beat, do its immediate work
    logic grant;       // grant the oldest waiter
    logic flush_ok;    // answer the pending flush as granted
    logic drop_tail;   // reject the newest waiter
    logic drop_flush;  // reject the pending flush
    logic rd_tail;     // queue read address: newest entry instead of oldest
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic imm_reply;   // request beat on the port gets a reply right away
    logic can_grant;   // room for a holder and someone waits
    logic flush_ready; // count is zero and a flush is pending
    logic fill_nz;     // queue holds at least one waiter
    logic fpend;       // a flush is pending
    logic last;        // reply in the output register is the final one
  } dp_stat_t;

endpackage

// ===== design/csf_dp.sv =====
// Datapath: count, limit, wait queue memory, pending flush and reply register.
`timescale 1ns / 1ps

module csf_dp import csf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LIMIT_W-1:0]    cfg_wdata_i,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [REQ_ID_W-1:0]   requester_id_i,
  input  ctrl_cmd_t             ctl_i,
  output dp_stat_t              stat_o,
  output logic [REPLY_ID_W-1:0] reply_id_o,
  output logic                  reply_kind_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  last_o
);

  localparam int unsigned KEEP_W = (ID_WIDTH < REQ_ID_W) ? ID_WIDTH : REQ_ID_W;
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = FILL_W + 1;
  localparam logic [SUM_W-1:0]  DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(QUEUE_DEPTH);

  // Pointer wrap; the sum is below twice the depth but for the tail address of an empty queue
  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return PTR_W'(t);
  endfunction

  logic [LIMIT_W-1:0] max_q, max_d;
  logic [LIMIT_W-1:0] cnt_q, cnt_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic               dead_q, dead_d;
  logic               fpend_q, fpend_d;
  logic [KEEP_W-1:0]  owner_q, owner_d;

  logic [KEEP_W-1:0]   mem [QUEUE_DEPTH];
  logic [KEEP_W-1:0]   rdata_q;
  logic [PTR_W-1:0]    waddr, raddr, tail_addr, head_next;
  logic                we;

  logic [KEEP_W-1:0]   rid_q, rid_d;
  logic                kind_q, kind_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                last_q, last_d;

  logic [KEEP_W-1:0]   in_id;
  logic                wait_grant, queue_full;

  assign in_id = requester_id_i[KEEP_W-1:0];

  // Queue addresses
  assign waddr     = wrap(SUM_W'(head_q) + SUM_W'(fill_q));
  assign tail_addr = wrap(SUM_W'(head_q) + SUM_W'(fill_q) - SUM_W'(1));
  assign head_next = wrap(SUM_W'(head_q) + SUM_W'(1));
  assign raddr     = ctl_i.rd_tail ? tail_addr : head_q;

  // Immediate decisions for the request on the port
  assign wait_grant = (cnt_q < max_q) && (fill_q == '0);
  assign queue_full = (fill_q == DEPTH_F);

  always_comb begin
    stat_o.imm_reply = 1'b0;
    case (cmd_i)
      CMD_WAIT:  stat_o.imm_reply = dead_q || wait_grant || queue_full;
      CMD_FLUSH: stat_o.imm_reply = dead_q || (cnt_q == '0);
      default:   stat_o.imm_reply = 1'b0;
    endcase
    stat_o.can_grant   = !dead_q && (cnt_q < max_q) && (fill_q != '0);
    stat_o.flush_ready = (cnt_q == '0) && fpend_q;
    stat_o.fill_nz     = (fill_q != '0);
    stat_o.fpend       = fpend_q;
    stat_o.last        = last_q;
  end

  // State updates and reply loading
  always_comb begin
    max_d   = cfg_we_i ? cfg_wdata_i : max_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    head_d  = head_q;
    dead_d  = dead_q;
    fpend_d = fpend_q;
    owner_d = owner_q;
    we      = 1'b0;
    rid_d   = rid_q;
    kind_d  = kind_q;
    stat_d  = stat_q;
    last_d  = last_q;

    if (ctl_i.accept) begin
      rid_d  = in_id;
      last_d = 1'b1;
      case (cmd_i)
        CMD_WAIT: begin
          kind_d = KIND_WAIT;
          if (dead_q) begin
            stat_d = STAT_REJECTED;
          end else if (wait_grant) begin
            cnt_d  = cnt_q + LIMIT_W'(1);
            stat_d = STAT_GRANTED;
          end else if (!queue_full) begin
            we     = 1'b1;
            fill_d = fill_q + FILL_W'(1);
          end else begin
            stat_d = STAT_FULL;
          end
        end
        CMD_SIGNAL: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - LIMIT_W'(1);
          end
        end
        CMD_FLUSH: begin
          kind_d = KIND_FLUSH;
          if (dead_q) begin
            stat_d = STAT_REJECTED;
          end else if (cnt_q == '0) begin
            stat_d = STAT_GRANTED;
          end else begin
            fpend_d = 1'b1;
            owner_d = in_id;
          end
        end
        CMD_DESTROY: begin
          dead_d = 1'b1;
          cnt_d  = '0;
        end
        default: ;
      endcase
    end

    // Oldest waiter takes a hold; a grant leaves the count nonzero
    if (ctl_i.grant) begin
      rid_d  = rdata_q;
      kind_d = KIND_WAIT;
      stat_d = STAT_GRANTED;
      last_d = !(((LIMIT_W + 1)'(cnt_q) + (LIMIT_W + 1)'(1) < (LIMIT_W + 1)'(max_q)) &&
                 (fill_q > FILL_W'(1)));
      cnt_d  = cnt_q + LIMIT_W'(1);
      fill_d = fill_q - FILL_W'(1);
      head_d = head_next;
    end

    if (ctl_i.flush_ok || ctl_i.drop_flush) begin
      rid_d   = owner_q;
      kind_d  = KIND_FLUSH;
      stat_d  = ctl_i.flush_ok ? STAT_GRANTED : STAT_REJECTED;
      last_d  = 1'b1;
      fpend_d = 1'b0;
    end

    // Newest waiter is rejected first
    if (ctl_i.drop_tail) begin
      rid_d  = rdata_q;
      kind_d = KIND_WAIT;
      stat_d = STAT_REJECTED;
      last_d = !((fill_q > FILL_W'(1)) || fpend_q);
      fill_d = fill_q - FILL_W'(1);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= LIMIT_W'(1);
      cnt_q   <= '0;
      fill_q  <= '0;
      head_q  <= '0;
      dead_q  <= 1'b0;
      fpend_q <= 1'b0;
      owner_q <= '0;
    end else begin
      max_q   <= max_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      head_q  <= head_d;
      dead_q  <= dead_d;
      fpend_q <= fpend_d;
      owner_q <= owner_d;
    end
  end

  // Wait queue memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_id;
    end
    rdata_q <= mem[raddr];
  end

  // Reply register
  always_ff @(posedge clk_i) begin
    rid_q  <= rid_d;
    kind_q <= kind_d;
    stat_q <= stat_d;
    last_q <= last_d;
  end

  assign reply_id_o   = REPLY_ID_W'(rid_q);
  assign reply_kind_o = kind_q;
  assign status_o     = stat_q;
  assign last_o       = last_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_F)
    else $error("queue fill above depth");

  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dead_q |-> cnt_q == '0)
    else $error("nonzero count after destroy");

  a_drop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.drop_tail |=> fill_q == $past(fill_q) - FILL_W'(1))
    else $error("reject did not shrink the queue");
`endif

endmodule

// ===== design/csf_ctrl.sv =====
// Controller: sequences accept, grant and drain steps and the reply handshake.
`timescale 1ns / 1ps

module csf_ctrl import csf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] cmd_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ctrl_cmd_t        ctl_o,
  input  dp_stat_t         stat_i
);

  state_e state_q, state_d;
  logic   drain_q, drain_d;  // 1 while a destroy drains the queue

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drain_q <= drain_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    drain_d       = drain_q;
    ctl_o         = '0;
    ctl_o.rd_tail = drain_q;
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);

    case (state_q)
      ST_IDLE: begin
        ctl_o.rd_tail = (cmd_i == CMD_DESTROY);
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          case (cmd_i)
            CMD_SIGNAL: begin
              state_d = ST_SIG;
              drain_d = 1'b0;
            end
            CMD_DESTROY: begin
              state_d = ST_DES;
              drain_d = 1'b1;
            end
            default: state_d = stat_i.imm_reply ? ST_OUT : ST_IDLE;
          endcase
        end
      end
      ST_SIG: begin
        if (stat_i.can_grant) begin
          ctl_o.grant = 1'b1;
          state_d     = ST_OUT;
        end else if (stat_i.flush_ready) begin
          ctl_o.flush_ok = 1'b1;
          state_d        = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DES: begin
        if (stat_i.fill_nz) begin
          ctl_o.drop_tail = 1'b1;
          state_d         = ST_OUT;
        end else if (stat_i.fpend) begin
          ctl_o.drop_flush = 1'b1;
          state_d          = ST_OUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = drain_q ? ST_DES : ST_SIG;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_more_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_stall_i && !stat_i.last) |=>
      (state_q == ST_SIG || state_q == ST_DES))
    else $error("reply chain ended early");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.accept, ctl_o.grant, ctl_o.flush_ok, ctl_o.drop_tail,
              ctl_o.drop_flush}))
    else $error("several datapath commands at once");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.grant |-> stat_i.can_grant)
    else $error("grant without room or waiter");
`endif

endmodule

// ===== design/counting_semaphore_fifo.sv =====
// Top level: counting semaphore with a FIFO of waiting requester ids.
//
//   channel   direction  handshake               payload
//   request   in         in_valid_i / in_stall_o  cmd_i, requester_id_i
//   reply     out        out_valid_o/out_stall_i  reply_id_o, reply_kind_o, status_o, last_o
//   limit     in         cfg_we_i                 cfg_wdata_i
//
// One request at a time. Wait and flush go from idle straight to their reply beat, if any.
// Signal and destroy pass through a grant or drain state before each reply beat,
// as each queue entry goes through the one registered read port of the queue memory.
// Reset clears count, queue pointers, destroyed flag and pending flush; the limit
// resets to 1. A stalled reply holds the controller until it is taken.
`timescale 1ns / 1ps

module counting_semaphore_fifo import csf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned ID_WIDTH    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [REQ_ID_W-1:0]   requester_id_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [REPLY_ID_W-1:0] reply_id_o,
  output logic                  reply_kind_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  last_o
);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  csf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl),
    .stat_i      (stat)
  );

  csf_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd_i),
    .requester_id_i (requester_id_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .reply_id_o     (reply_id_o),
    .reply_kind_o   (reply_kind_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// ===== tb/csf_reply_checker.sv =====
// Reply checker: predicts the semaphore's replies and compares every reply beat.
`timescale 1ns / 1ps

module csf_reply_checker import csf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [LIMIT_W-1:0]    cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [REQ_ID_W-1:0]   requester_id_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [REPLY_ID_W-1:0] reply_id_i,
  input  logic                  reply_kind_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic                  last_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    req_cnt_o,
  output int                    reply_cnt_o,
  output int                    grant_cnt_o,
  output int                    reject_cnt_o,
  output int                    full_cnt_o,
  output int                    flush_cnt_o
);

  typedef struct packed {
    logic [REPLY_ID_W-1:0] id;
    logic                  kind;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } reply_t;

  // Replies still owed by the block, oldest first
  reply_t replies_due[$];

  // Predicted semaphore state
  logic [LIMIT_W-1:0]  limit_q;
  logic [7:0]          holders;
  logic [REQ_ID_W-1:0] waiters [QUEUE_DEPTH];
  int unsigned         fill;
  int unsigned         head;
  logic                dead;
  logic                fl_pend;
  logic [REQ_ID_W-1:0] fl_owner;

  task automatic owe_reply(input logic [REPLY_ID_W-1:0] id, input logic kind,
                           input logic [STATUS_W-1:0] st);
    reply_t r;
    r.id     = id;
    r.kind   = kind;
    r.status = st;
    r.last   = 1'b0;
    replies_due.insert(replies_due.size(), r);
  endtask

  // Apply one request beat to the predicted state, queue the replies it causes
  task automatic predict_request(input logic [CMD_W-1:0] c, input logic [REQ_ID_W-1:0] id);
    int first;
    first = replies_due.size();
    case (c)
      CMD_WAIT: begin
        if (dead) begin
          owe_reply(id, KIND_WAIT, STAT_REJECTED);
        end else if (holders < limit_q && fill == 0) begin
          holders++;
          owe_reply(id, KIND_WAIT, STAT_GRANTED);
        end else if (fill < QUEUE_DEPTH) begin
          waiters[(head + fill) % QUEUE_DEPTH] = id;
          fill++;
        end else begin
          owe_reply(id, KIND_WAIT, STAT_FULL);
        end
      end
      CMD_SIGNAL: begin
        if (holders > 0) holders--;
        // hand freed slots to the oldest waiters
        while (holders < limit_q && fill > 0 && !dead) begin
          holders++;
          owe_reply(waiters[head], KIND_WAIT, STAT_GRANTED);
          head = (head + 1) % QUEUE_DEPTH;
          fill--;
        end
        if (holders == 0 && fl_pend) begin
          fl_pend = 1'b0;
          owe_reply(fl_owner, KIND_FLUSH, STAT_GRANTED);
        end
      end
      CMD_FLUSH: begin
        if (dead) begin
          owe_reply(id, KIND_FLUSH, STAT_REJECTED);
        end else if (holders == 0) begin
          owe_reply(id, KIND_FLUSH, STAT_GRANTED);
        end else begin
          fl_pend  = 1'b1;
          fl_owner = id;
        end
      end
      default: begin
        // destroy: reject waiters newest first, then the pending flush
        dead    = 1'b1;
        holders = '0;
        while (fill > 0) begin
          fill--;
          owe_reply(waiters[(head + fill) % QUEUE_DEPTH], KIND_WAIT, STAT_REJECTED);
        end
        if (fl_pend) begin
          fl_pend = 1'b0;
          owe_reply(fl_owner, KIND_FLUSH, STAT_REJECTED);
        end
      end
    endcase
    if (replies_due.size() > first) begin
      replies_due[replies_due.size() - 1].last = 1'b1;
    end
  endtask

  // Compare one reply beat against the oldest owed reply
  task automatic check_reply();
    reply_t want;
    reply_cnt_o++;
    if (status_i == STAT_GRANTED)  grant_cnt_o++;
    if (status_i == STAT_REJECTED) reject_cnt_o++;
    if (status_i == STAT_FULL)     full_cnt_o++;
    if (reply_kind_i == KIND_FLUSH) flush_cnt_o++;
    if (replies_due.size() == 0) begin
      fail_cnt_o++;
      if (fail_cnt_o <= 10)
        $display("%0t: unexpected reply beat id=%0d kind=%0d status=%0d last=%0d",
                 $realtime, reply_id_i, reply_kind_i, status_i, last_i);
    end else begin
      want = replies_due[0];
      replies_due.delete(0);
      if (reply_id_i !== want.id || reply_kind_i !== want.kind ||
          status_i !== want.status || last_i !== want.last) begin
        fail_cnt_o++;
        if (fail_cnt_o <= 10) begin
          $display("%0t: reply %0d expected id=%0d kind=%0d status=%0d last=%0d",
                   $realtime, reply_cnt_o, want.id, want.kind, want.status, want.last);
          $display("    got id=%0d kind=%0d status=%0d last=%0d",
                   reply_id_i, reply_kind_i, status_i, last_i);
        end
      end
    end
  endtask

  // Sample both channels and the limit port on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replies_due.delete();
      limit_q      = 8'd1;
      holders      = '0;
      fill         = 0;
      head         = 0;
      dead         = 1'b0;
      fl_pend      = 1'b0;
      fl_owner     = '0;
      fail_cnt_o   = 0;
      pending_o    = 0;
      req_cnt_o    = 0;
      reply_cnt_o  = 0;
      grant_cnt_o  = 0;
      reject_cnt_o = 0;
      full_cnt_o   = 0;
      flush_cnt_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_reply();
      if (in_valid_i && !in_stall_i) begin
        req_cnt_o++;
        predict_request(cmd_i, requester_id_i);
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      pending_o = replies_due.size();
    end
  end

endmodule

// ===== tb/tb_counting_semaphore_fifo.sv =====
// Testbench top: request stimulus, reply stall pattern, limit writes and verdict.
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo;
  import csf_pkg::*;

  localparam int unsigned QDEPTH = 32;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd        = CMD_WAIT;
  logic [REQ_ID_W-1:0]   req_id     = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [REPLY_ID_W-1:0] reply_id;
  logic                  reply_kind;
  logic [STATUS_W-1:0]   status;
  logic                  last_beat;

  int fail_cnt, pending, req_cnt, reply_cnt, grant_cnt, reject_cnt, full_cnt, flush_cnt;

  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int stall_left = 0;
  int stall_roll;

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  counting_semaphore_fifo #(
    .QUEUE_DEPTH(QDEPTH),
    .ID_WIDTH   (8)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .cmd_i         (cmd),
    .requester_id_i(req_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .reply_id_o    (reply_id),
    .reply_kind_o  (reply_kind),
    .status_o      (status),
    .last_o        (last_beat)
  );

  csf_reply_checker #(.QUEUE_DEPTH(QDEPTH)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .cmd_i         (cmd),
    .requester_id_i(req_id),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .reply_id_i    (reply_id),
    .reply_kind_i  (reply_kind),
    .status_i      (status),
    .last_i        (last_beat),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .req_cnt_o     (req_cnt),
    .reply_cnt_o   (reply_cnt),
    .grant_cnt_o   (grant_cnt),
    .reject_cnt_o  (reject_cnt),
    .full_cnt_o    (full_cnt),
    .flush_cnt_o   (flush_cnt)
  );

  // Reply side stall: mostly short bursts, a few long ones, calm stretches in between
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 75) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one request beat from a falling edge, return at the falling edge after it is taken
  task automatic send_req(input logic [CMD_W-1:0] c, input logic [REQ_ID_W-1:0] id);
    int gap;
    gap = pick_gap();
    if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    req_id   <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the limit once every owed reply is in and the block has settled
  task automatic set_limit(input logic [LIMIT_W-1:0] v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random wait/signal/flush mix at one limit setting
  task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int n, input int wait_pct);
    int r;
    logic [CMD_W-1:0] c;
    set_limit(lim);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < wait_pct) c = CMD_WAIT;
      else if (r < wait_pct + (100 - wait_pct) * 3 / 4) c = CMD_SIGNAL;
      else c = CMD_FLUSH;
      send_req(c, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset limit of one: signal and flush at zero count, queueing, flush replacement
    send_req(CMD_SIGNAL, 8'h3C);
    send_req(CMD_FLUSH, 8'h00);
    send_req(CMD_WAIT, 8'h00);
    send_req(CMD_WAIT, 8'hFF);
    send_req(CMD_FLUSH, 8'hAA);
    send_req(CMD_FLUSH, 8'h55);
    send_req(CMD_SIGNAL, 8'h00);
    send_req(CMD_SIGNAL, 8'hFF);

    // Limit lowered under the count: no grant until the count drops below it
    set_limit(8'd3);
    send_req(CMD_WAIT, 8'h01);
    send_req(CMD_WAIT, 8'h80);
    send_req(CMD_WAIT, 8'h7F);
    set_limit(8'd1);
    send_req(CMD_WAIT, 8'hC3);
    send_req(CMD_FLUSH, 8'h96);
    send_req(CMD_SIGNAL, 8'h00);
    send_req(CMD_SIGNAL, 8'h00);
    send_req(CMD_SIGNAL, 8'h00);
    send_req(CMD_SIGNAL, 8'h00);

    // Random phases, limit zero first to fill the queue and hit refusals
    run_phase(8'd0, 60, 85);
    run_phase(8'd255, 50, 40);
    run_phase(8'd5, 60, 60);
    run_phase(8'd2, 60, 45);
    run_phase(8'($urandom_range(1, 8)), 60, 50);
    run_phase(8'd1, 60, 50);

    // Full queue plus pending flush, then destroy and requests to a dead block
    set_limit(8'd1);
    repeat (34) send_req(CMD_WAIT, 8'($urandom_range(0, 255)));
    send_req(CMD_FLUSH, 8'($urandom_range(0, 255)));
    send_req(CMD_DESTROY, 8'($urandom_range(0, 255)));
    send_req(CMD_WAIT, 8'h5A);
    send_req(CMD_FLUSH, 8'hA5);
    send_req(CMD_SIGNAL, 8'h00);
    send_req(CMD_DESTROY, 8'h00);
    repeat (10) send_req(CMD_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    // Drain, then a settle window for stray beats
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Ran %0d requests over limits 1, 3, 1, 0, 255, 5, 2, random and 1, then destroy.",
             req_cnt);
    $display("Saw %0d replies: %0d granted, %0d rejected, %0d full, %0d flush; %0d mismatches.",
             reply_cnt, grant_cnt, reject_cnt, full_cnt, flush_cnt, fail_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #16_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
design/csf_pkg.sv
design/csf_dp.sv
design/csf_ctrl.sv
design/counting_semaphore_fifo.sv
tb/csf_reply_checker.sv
tb/tb_counting_semaphore_fifo.sv
